@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NVC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/nvc_pkg.sv @@
// Shared types and constants for the NV21 frame crop block.
// No dependencies.
package nvc_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int CAP_W     = 25;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_LEFT       = 3'd2,
    REG_TOP        = 3'd3,
    REG_RIGHT      = 3'd4,
    REG_BOTTOM     = 3'd5,
    REG_DEST_CAP   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_CAP   = 2'd2,
    ST_ODD   = 2'd3
  } status_t;

  localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 13'd480;
  localparam logic [DIM_W-1:0] RST_RIGHT      = 13'd640;
  localparam logic [DIM_W-1:0] RST_BOTTOM     = 13'd480;
  localparam logic [CAP_W-1:0] RST_DEST_CAP   = 25'd460800;

endpackage

@@ rtl/core/nvc_if.sv @@
// Valid/ready stream interfaces for the NV21 frame crop block.
// Depends on nvc_pkg.
interface nvc_in_if import nvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;
  logic             frame_start;

  modport source (output valid, pixel_byte, frame_start, input ready);
  modport sink   (input valid, pixel_byte, frame_start, output ready);
  modport mon    (input valid, ready, pixel_byte, frame_start);
endinterface

interface nvc_out_if import nvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_byte;
  logic             is_last;
  logic [1:0]       status;

  modport source (output valid, out_byte, is_last, status, input ready);
  modport sink   (input valid, out_byte, is_last, status, output ready);
  modport mon    (input valid, ready, out_byte, is_last, status);
endinterface

@@ rtl/core/nv21_frame_crop.sv @@
// NV21 frame crop: top level with config registers, crop counters and output register.
// Depends on nvc_pkg and the stream interfaces in nvc_if.sv.
//
// Usage:
//  - in_ch carries the source frame one byte per request in raster order: luma plane,
//    then the interleaved VU plane. frame_start marks the first byte of a frame.
//  - out_ch carries the kept bytes (status ok), is_last on the final chroma byte.
//    A bad setting found on the frame_start byte gives a single request with
//    out_byte 0, is_last 1 and the error status; the rest of that frame is dropped.
//  - cfg_we/cfg_idx/cfg_wdata write the crop registers; write only while idle.
//  - Path: an accepted request moves from the input register to the output register.
//  - Throughput: one byte per cycle while out_ch.ready is high. The input register
//    drains into the output register when that is empty or read, so in_ch stays ready
//    while a result waits only if the input register is empty; the per-byte work
//    is the counter compares plus the frame-start check (13x13 area multiply, compare).
//  - Stall: when out_ch.ready stays low with a result held, the input register fills
//    and in_ch.ready drops after one more request.
//  - Reset (rst_n low, synchronous): both stages empty, counters cleared, waiting
//    for a frame start; registers return to 640x480, full-frame crop, 460800 bytes.
module nv21_frame_crop import nvc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nvc_in_if.sink               in_ch,
  nvc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CAP_W-1:0]     cfg_wdata
);

  localparam int DX_W   = DIM_W + 1;     // room for count + 1
  localparam int AREA_W = 2 * DIM_W;
  localparam int NEED_W = AREA_W + 2;    // 3 * area

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0] src_w_r, src_h_r, left_r, top_r, right_r, bottom_r;
  logic [CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= RST_SRC_WIDTH;
      src_h_r  <= RST_SRC_HEIGHT;
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= RST_RIGHT;
      bottom_r <= RST_BOTTOM;
      cap_r    <= RST_DEST_CAP;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_SRC_WIDTH:  src_w_r  <= cfg_wdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_r  <= cfg_wdata[DIM_W-1:0];
        REG_LEFT:       left_r   <= cfg_wdata[DIM_W-1:0];
        REG_TOP:        top_r    <= cfg_wdata[DIM_W-1:0];
        REG_RIGHT:      right_r  <= cfg_wdata[DIM_W-1:0];
        REG_BOTTOM:     bottom_r <= cfg_wdata[DIM_W-1:0];
        REG_DEST_CAP:   cap_r    <= cfg_wdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_byte_r;
  logic             s1_start_r;
  logic             out_valid_r;
  logic             s1_fire;
  logic             in_acc;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_ch.pixel_byte;
      s1_start_r <= in_ch.frame_start;
    end
  end

  // ---------------- frame-start check ----------------
  // Order: range, then capacity, then evenness.
  logic              range_bad;
  logic [DIM_W-1:0]  crop_w, crop_h;
  logic [AREA_W-1:0] area;
  logic [NEED_W-1:0] need3, cap2;
  logic              odd_coord;
  status_t           chk;

  always_comb begin
    range_bad = ({1'b0, src_w_r} > DX_W'(MAX_DIM)) || ({1'b0, src_h_r} > DX_W'(MAX_DIM))
             || (left_r > src_w_r) || (right_r > src_w_r)
             || (top_r > src_h_r) || (bottom_r > src_h_r)
             || (right_r <= left_r) || (bottom_r <= top_r);
    crop_w    = right_r - left_r;
    crop_h    = bottom_r - top_r;
    area      = AREA_W'(crop_w) * AREA_W'(crop_h);
    need3     = NEED_W'(area) + NEED_W'({area, 1'b0});
    cap2      = NEED_W'({cap_r, 1'b0});
    odd_coord = left_r[0] | top_r[0] | right_r[0] | bottom_r[0];
    if (range_bad)          chk = ST_RANGE;
    else if (need3 > cap2)  chk = ST_CAP;
    else if (odd_coord)     chk = ST_ODD;
    else                    chk = ST_OK;
  end

  // ---------------- crop counters ----------------
  logic [DIM_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic             chroma_r, active_r, chroma_nxt, active_nxt;

  logic [DIM_W-1:0] c_cur, r_cur, r_inc, top_c;
  logic             ch_cur, act_cur, err;
  logic [DX_W-1:0]  c_inc, end_c;
  logic             col_in, row_in_l, row_in_c, keep, last, wrap;

  always_comb begin
    // a frame start restarts the counters before the byte is looked at
    c_cur   = s1_start_r ? '0 : col_r;
    r_cur   = s1_start_r ? '0 : row_r;
    ch_cur  = s1_start_r ? 1'b0 : chroma_r;
    act_cur = s1_start_r ? (chk == ST_OK) : active_r;
    err     = s1_start_r && (chk != ST_OK);

    top_c    = top_r >> 1;
    end_c    = DX_W'(top_c) + DX_W'(DIM_W'(bottom_r - top_r) >> 1);
    col_in   = (c_cur >= left_r) && (c_cur < right_r);
    row_in_l = (r_cur >= top_r) && (r_cur < bottom_r);
    row_in_c = (bottom_r > top_r) && (r_cur >= top_c) && (DX_W'(r_cur) < end_c);
    keep     = act_cur && col_in && (ch_cur ? row_in_c : row_in_l);
    last     = keep && ch_cur && ((DX_W'(r_cur) + 1'b1) == end_c)
             && ((DX_W'(c_cur) + 1'b1) == DX_W'(right_r));

    c_inc = DX_W'(c_cur) + 1'b1;
    wrap  = c_inc >= DX_W'(src_w_r);
    r_inc = r_cur + 1'b1;

    col_nxt    = col_r;
    row_nxt    = row_r;
    chroma_nxt = chroma_r;
    active_nxt = active_r;
    if (s1_fire) begin
      if (err) begin
        col_nxt    = '0;
        row_nxt    = '0;
        chroma_nxt = 1'b0;
        active_nxt = 1'b0;
      end else if (!act_cur) begin
        col_nxt    = c_cur;
        row_nxt    = r_cur;
        chroma_nxt = ch_cur;
        active_nxt = 1'b0;
      end else begin
        col_nxt    = wrap ? '0 : c_inc[DIM_W-1:0];
        row_nxt    = r_cur;
        chroma_nxt = ch_cur;
        active_nxt = !last;
        if (wrap) begin
          row_nxt = r_inc;
          if (!ch_cur) begin
            if (r_inc >= src_h_r) begin
              chroma_nxt = 1'b1;
              row_nxt    = '0;
            end
          end else if (r_inc >= (src_h_r >> 1)) begin
            active_nxt = 1'b0;  // past the end of the chroma plane
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      chroma_r <= 1'b0;
      active_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chroma_r <= chroma_nxt;
      active_r <= active_nxt;
    end
  end

  // ---------------- output register ----------------
  logic             out_load;
  logic [PIX_W-1:0] out_byte_r;
  logic             out_last_r;
  status_t          out_status_r;

  assign out_load = s1_fire && (err || keep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r   <= err ? '0 : s1_byte_r;
      out_last_r   <= err || last;
      out_status_r <= err ? chk : ST_OK;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.is_last  = out_last_r;
  assign out_ch.status   = out_status_r;

endmodule

@@ rtl/core/nvc_checker.sv @@
// Port-level checks for nv21_frame_crop, bound to the top level.
// Depends on nvc_pkg, nvc_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module nvc_checker import nvc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  nvc_in_if.sink    in_ch,
  nvc_out_if.source out_ch
);

  // held result keeps its payload
  `NVC_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.out_byte) && $stable(out_ch.is_last) && $stable(out_ch.status), "stalled result changed")

  // error results are a single marked zero byte
  `NVC_ASSERT_NOW(a_err_form, clk, rst_n, out_ch.valid && (out_ch.status != ST_OK), out_ch.is_last && (out_ch.out_byte == '0), "error result malformed")

  // input only backs up behind a stalled output
  `NVC_ASSERT_NOW(a_in_stall, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output stall")

  // a new result needs an accepted request earlier on in_ch
  `NVC_ASSERT_NOW(a_no_invent, clk, rst_n, $rose(out_ch.valid), $past(in_ch.valid && in_ch.ready, 2), "result without request")

endmodule

bind nv21_frame_crop nvc_checker u_nvc_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

@@ dv/nvc_crop_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for nv21_frame_crop: tracks config writes, predicts the kept bytes and
// compares them with what leaves out_ch. Depends on nvc_pkg and the nvc_if interfaces.
module nvc_crop_checker import nvc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nvc_in_if.mon                in_ch,
  nvc_out_if.mon               out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CAP_W-1:0]     cfg_wdata,
  output int                   pending,
  output int                   mismatches
);

  typedef struct packed {
    logic [PIX_W-1:0] data;
    logic             last;
    status_t          st;
  } crop_byte_t;

  logic [DIM_W-1:0] src_w, src_h, left_c, top_r, right_c, bottom_r;
  logic [CAP_W-1:0] dest_cap;
  logic [DIM_W-1:0] col, row;
  logic             chroma, active;
  crop_byte_t       expected_bytes[$];

  function automatic status_t frame_status();
    longint unsigned w, h;
    if (src_w > MAX_DIM || src_h > MAX_DIM) return ST_RANGE;
    if (left_c > src_w || right_c > src_w || top_r > src_h || bottom_r > src_h) return ST_RANGE;
    if (right_c <= left_c || bottom_r <= top_r) return ST_RANGE;
    w = right_c - left_c;
    h = bottom_r - top_r;
    if (3 * w * h > 2 * longint'(dest_cap)) return ST_CAP;
    if (left_c[0] | top_r[0] | right_c[0] | bottom_r[0]) return ST_ODD;
    return ST_OK;
  endfunction

  // One source byte through the crop counters; returns 1 when it yields a result.
  function automatic bit crop_step(input logic [PIX_W-1:0] b, input logic start,
                                   output crop_byte_t res);
    status_t st;
    bit      keep, last;
    int      top_c, end_c, nxt;
    last = 1'b0;
    res  = '0;
    if (start) begin
      st     = frame_status();
      col    = '0;
      row    = '0;
      chroma = 1'b0;
      if (st != ST_OK) begin
        active = 1'b0;
        res    = '{data: '0, last: 1'b1, st: st};
        return 1'b1;
      end
      active = 1'b1;
    end
    if (!active) return 1'b0;

    keep = col >= left_c && col < right_c;
    if (!chroma) begin
      keep = keep && row >= top_r && row < bottom_r;
    end else begin
      top_c = int'(top_r) >> 1;
      end_c = top_c + ((int'(bottom_r) - int'(top_r)) >>> 1);
      keep  = keep && bottom_r > top_r && int'(row) >= top_c && int'(row) < end_c;
      last  = keep && int'(row) + 1 == end_c && int'(col) + 1 == int'(right_c);
    end

    // column wrap also covers a width shrunk under a running frame
    nxt = int'(col) + 1;
    if (nxt >= int'(src_w)) begin
      nxt = 0;
      row = row + 1'b1;
      if (!chroma) begin
        if (row >= src_h) begin
          chroma = 1'b1;
          row    = '0;
        end
      end else if (row >= (src_h >> 1)) begin
        active = 1'b0;
      end
    end
    col = nxt[DIM_W-1:0];

    if (!keep) return 1'b0;
    if (last) active = 1'b0;
    res = '{data: b, last: last, st: ST_OK};
    return 1'b1;
  endfunction

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    crop_byte_t want, got;
    if (!rst_n) begin
      src_w    = RST_SRC_WIDTH;
      src_h    = RST_SRC_HEIGHT;
      left_c   = '0;
      top_r    = '0;
      right_c  = RST_RIGHT;
      bottom_r = RST_BOTTOM;
      dest_cap = RST_DEST_CAP;
      col      = '0;
      row      = '0;
      chroma   = 1'b0;
      active   = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_SRC_WIDTH:  src_w    = cfg_wdata[DIM_W-1:0];
          REG_SRC_HEIGHT: src_h    = cfg_wdata[DIM_W-1:0];
          REG_LEFT:       left_c   = cfg_wdata[DIM_W-1:0];
          REG_TOP:        top_r    = cfg_wdata[DIM_W-1:0];
          REG_RIGHT:      right_c  = cfg_wdata[DIM_W-1:0];
          REG_BOTTOM:     bottom_r = cfg_wdata[DIM_W-1:0];
          REG_DEST_CAP:   dest_cap = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready && crop_step(in_ch.pixel_byte, in_ch.frame_start, want))
        expected_bytes.push_back(want);
      if (out_ch.valid && out_ch.ready) begin
        got = '{data: out_ch.out_byte, last: out_ch.is_last, st: status_t'(out_ch.status)};
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0d, is_last %0d, status %0d",
                 got.data, got.last, got.st);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          compare_field("out_byte", want.data, got.data);
          compare_field("is_last", want.last, got.last);
          compare_field("status", want.st, got.st);
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the nv21_frame_crop bench: clock, reset, crop settings and byte stimulus.
// Depends on nvc_pkg, the nvc_if interfaces, the block and nvc_crop_checker.
module testbench import nvc_pkg::*;;

  localparam int STALL_LIMIT  = 1000; // cycles with no request moving on either side
  localparam int TARGET_ITEMS = 1350;
  localparam int CALM_AFTER   = 1150; // no gaps or stalls past this many bytes
  localparam int DRAIN_CYCLES = 4;    // slack after the scoreboard queue empties

  // one crop setting, fields in register order
  typedef struct {
    int w, h, x0, y0, x1, y1, cap;
    bit faulty;
  } crop_setup_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CAP_W-1:0]     cfg_wdata;

  nvc_in_if  in_ch ();
  nvc_out_if out_ch ();

  int pending, mismatches;
  int sent;
  bit calm;
  int gap_pct, stall_pct;
  int stall_left;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nv21_frame_crop u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  nvc_crop_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // Result side backpressure: ready drops in bursts whose start is drawn against stall_pct.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake or a result that never shows ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One byte request. valid stays high after acceptance so back-to-back bytes
  // never lower and raise it in the same step; drain() drops it.
  task automatic push_byte(input logic [PIX_W-1:0] b, input logic start);
    int gap;
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_byte  <= b;
    in_ch.frame_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (sent >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) push_byte(PIX_W'($urandom_range(255)), i == 0);
  endtask

  task automatic send_loose(input int len);
    for (int i = 0; i < len; i++) push_byte(PIX_W'($urandom_range(255)), 1'b0);
  endtask

  // Block idle: nothing in flight, every predicted result delivered.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high so a group of writes runs back to back; caller lowers it.
  task automatic poke_reg(input cfg_reg_t r, input int val);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= CAP_W'(val);
    @(posedge clk);
  endtask

  task automatic load_setup(input crop_setup_t c);
    poke_reg(REG_SRC_WIDTH, c.w);
    poke_reg(REG_SRC_HEIGHT, c.h);
    poke_reg(REG_LEFT, c.x0);
    poke_reg(REG_TOP, c.y0);
    poke_reg(REG_RIGHT, c.x1);
    poke_reg(REG_BOTTOM, c.y1);
    poke_reg(REG_DEST_CAP, c.cap);
    cfg_we <= 1'b0;
  endtask

  // Mostly good small frames (odd source sizes allowed); the rest trip one check.
  function automatic crop_setup_t pick_setup();
    crop_setup_t c;
    int area, kind;
    c.w  = $urandom_range(2, 17);
    c.h  = $urandom_range(2, 12);
    c.x0 = 2 * $urandom_range(0, c.w / 2 - 1);
    c.x1 = 2 * $urandom_range(c.x0 / 2 + 1, c.w / 2);
    c.y0 = 2 * $urandom_range(0, c.h / 2 - 1);
    c.y1 = 2 * $urandom_range(c.y0 / 2 + 1, c.h / 2);
    area = 3 * (c.x1 - c.x0) * (c.y1 - c.y0) / 2;
    // capacity right on the limit now and then
    c.cap    = ($urandom_range(3) == 0) ? area : area + $urandom_range(1, 1000);
    c.faulty = 1'b1;
    kind     = $urandom_range(99);
    if (kind < 70) begin
      c.faulty = 1'b0;
    end else if (kind < 80) begin
      c.cap = $urandom_range(0, area - 1);
    end else if (kind < 90) begin
      case ($urandom_range(3))
        0: c.x0 ^= 1;
        1: c.y0 ^= 1;
        2: c.x1 ^= 1;
        default: c.y1 ^= 1;
      endcase
    end else begin
      case ($urandom_range(3))
        0: c.w  = $urandom_range(MAX_DIM + 1, 8191);
        1: c.x1 = c.x0;
        2: c.y1 = c.h + 2;
        default: c.y0 = c.y1;
      endcase
    end
    return c;
  endfunction

  initial begin
    crop_setup_t setup;
    int full, frames, kind, part, nw;

    in_ch.valid       = 1'b0;
    in_ch.pixel_byte  = '0;
    in_ch.frame_start = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_SRC_WIDTH;
    cfg_wdata         = '0;
    gap_pct           = 0;
    stall_pct         = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // 4x2 full crop with capacity exactly 3*w*h/2
    load_setup('{4, 2, 0, 0, 4, 2, 12, 1'b0});
    // bytes with no frame running are dropped
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // frame cut short, then restarted by a new frame start
    push_byte(8'h11, 1'b1);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    // full frame: 8 luma + 4 VU bytes, last chroma byte flagged
    for (int i = 0; i < 12; i++) push_byte(i == 1 ? 8'hFF : PIX_W'(i * 37), i == 0);
    // past the last kept byte: ignored
    push_byte(8'hA5, 1'b0);
    drain();

    // largest source, full crop, largest capacity: accepted
    load_setup('{MAX_DIM, MAX_DIM, 0, 0, MAX_DIM, MAX_DIM, 25165824, 1'b0});
    send_frame(3);
    drain();
    // one byte short on capacity; the rest of the frame is dropped
    load_setup('{MAX_DIM, MAX_DIM, 0, 0, MAX_DIM, MAX_DIM, 25165823, 1'b0});
    send_frame(2);
    drain();
    // width beyond the supported maximum, no capacity at all
    load_setup('{8191, 2, 0, 0, 2, 2, 0, 1'b1});
    send_frame(1);
    drain();
    // odd left/right coordinates
    load_setup('{4, 2, 1, 0, 3, 2, 25165824, 1'b1});
    send_frame(2);

    // ---- random part ----
    gap_pct   = 20;
    stall_pct = 20;
    while (sent < TARGET_ITEMS) begin
      drain();
      setup = pick_setup();
      load_setup(setup);
      // some phases run without any idling
      gap_pct   = 20 * $urandom_range(2);
      stall_pct = 20 * $urandom_range(2);
      frames    = $urandom_range(1, 3);
      for (int f = 0; f < frames && sent < TARGET_ITEMS; f++) begin
        full = setup.w * setup.h + setup.w * (setup.h / 2);
        kind = $urandom_range(99);
        if (setup.faulty) begin
          // error result, then a few dropped bytes
          send_frame($urandom_range(1, 5));
        end else if (kind < 65) begin
          // whole frame plus a few stray bytes past the chroma plane
          send_frame(full);
          send_loose($urandom_range(0, 2));
        end else if (kind < 78) begin
          // cut short; the next frame start restarts the counters
          send_frame($urandom_range(1, full - 1));
        end else if (kind < 90) begin
          // width rewritten while the frame is running
          part = $urandom_range(1, full - 1);
          send_frame(part);
          drain();
          nw = $urandom_range(2, 17);
          poke_reg(REG_SRC_WIDTH, nw);
          cfg_we <= 1'b0;
          setup.w = nw;
          send_loose($urandom_range(0, setup.w * setup.h * 3 / 2 + 2));
        end else begin
          // noise with no frame start, then a whole frame
          send_loose($urandom_range(1, 3));
          send_frame(full);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
